>>> hw/rtl/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg
// Shared codes, controller command and datapath status types for the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bde_pkg;

    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 2;

    // command codes (s_axis_tuser)
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // result status codes (m_axis_tuser)
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // ring address source
    typedef enum logic [2:0] {
        ASEL_HEAD,
        ASEL_FRONT_NEW,
        ASEL_REAR_FREE,
        ASEL_REAR_LAST,
        ASEL_DUMP
    } t_asel;

    // pointer / count update
    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_PUSH_REAR,
        UPD_PUSH_FRONT,
        UPD_POP_REAR,
        UPD_POP_FRONT
    } t_upd;

    typedef struct packed {
        logic             cap;        // capture input word
        logic             ram_wr;
        logic             ram_rd;
        t_asel            asel;
        t_upd             upd;
        logic             emit;       // load output register
        logic [ST_W-1:0]  emit_status;
        logic             emit_ram;   // word from ring read, else zero
        logic             emit_last;
        logic             dump_clr;
        logic             dump_inc;
    } t_ctl_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic dump_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/bde_ram.sv
// ----------------------------------------------------------------------------
// bde_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/bde_dpath.sv
// ----------------------------------------------------------------------------
// bde_dpath
// Ring store, head pointer, occupancy, dump index and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_dpath #(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bde_pkg::t_ctl_cmd             i_ctl,
    input  wire logic [bde_pkg::WORD_W-1:0]    i_value,
    output bde_pkg::t_dp_stat                  o_stat,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [bde_pkg::WORD_W-1:0]    o_m_tdata,
    output logic      [bde_pkg::ST_W-1:0]      o_m_tuser,
    output logic                               o_m_tlast
);

    import bde_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(DEPTH);

    logic [IW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_occ, n_occ;
    logic [IW-1:0]     r_dump_idx;
    logic [WORD_W-1:0] r_value;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;
    logic [ST_W-1:0]   r_out_status;
    logic              r_out_last;

    logic [IW:0]       offset;
    logic [IW:0]       slot_sum;
    logic [IW-1:0]     slot;
    logic [IW-1:0]     head_dec;
    logic [IW-1:0]     head_inc;
    logic [IW-1:0]     addr;
    logic [WORD_W-1:0] rd_data;

    // head + offset modulo DEPTH; the sum stays below twice DEPTH
    always_comb begin
        case (i_ctl.asel)
            ASEL_REAR_FREE: offset = (IW + 1)'(r_occ);
            ASEL_REAR_LAST: offset = (IW + 1)'(r_occ - CW'(1));
            ASEL_DUMP:      offset = (IW + 1)'(r_dump_idx);
            default:        offset = '0;
        endcase
        slot_sum = (IW + 1)'(r_head) + offset;
        slot     = (slot_sum >= DEPTH_X) ? IW'(slot_sum - DEPTH_X) : IW'(slot_sum);
        head_dec = (r_head == '0) ? LAST_SLOT : r_head - IW'(1);
        head_inc = (r_head == LAST_SLOT) ? '0 : r_head + IW'(1);
        addr     = (i_ctl.asel == ASEL_FRONT_NEW) ? head_dec : slot;
    end

    always_comb begin
        n_head = r_head;
        n_occ  = r_occ;
        case (i_ctl.upd)
            UPD_PUSH_REAR: n_occ = r_occ + CW'(1);
            UPD_PUSH_FRONT: begin
                n_head = head_dec;
                n_occ  = r_occ + CW'(1);
            end
            UPD_POP_REAR: n_occ = r_occ - CW'(1);
            UPD_POP_FRONT: begin
                n_head = head_inc;
                n_occ  = r_occ - CW'(1);
            end
            default: ;
        endcase
    end

    bde_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.ram_wr),
        .i_wr_addr (addr),
        .i_wr_data (r_value),
        .i_rd_en   (i_ctl.ram_rd),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_occ       <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_occ  <= n_occ;
            if (i_ctl.dump_clr) begin
                r_dump_idx <= '0;
            end else if (i_ctl.dump_inc) begin
                r_dump_idx <= r_dump_idx + IW'(1);
            end
            if (i_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_value <= i_value;
        end
        if (i_ctl.emit) begin
            r_out_data   <= i_ctl.emit_ram ? rd_data : '0;
            r_out_status <= i_ctl.emit_status;
            r_out_last   <= i_ctl.emit_last;
        end
    end

    assign o_stat.empty     = (r_occ == '0);
    assign o_stat.full      = (r_occ == CW'(DEPTH));
    assign o_stat.out_free  = !r_out_valid || i_m_tready;
    assign o_stat.dump_last = ((CW'(r_dump_idx) + CW'(1)) == r_occ);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> hw/rtl/bde_ctrl.sv
// ----------------------------------------------------------------------------
// bde_ctrl
// Command sequencer: decodes each command and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [bde_pkg::CMD_W-1:0]   i_cmd,
    input  wire bde_pkg::t_dp_stat           i_stat,
    output bde_pkg::t_ctl_cmd                o_ctl
);

    import bde_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [CMD_W-1:0]   r_cmd;
    t_ctl_cmd           ctl;
    logic               accept;

    assign accept = i_s_tvalid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        ctl.cap = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd) inside
                    CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
                        if (i_stat.out_free) begin
                            ctl.emit        = 1'b1;
                            ctl.emit_last   = 1'b1;
                            ctl.emit_status = i_stat.full ? ST_FULL : ST_OK;
                            if (!i_stat.full) begin
                                ctl.ram_wr = 1'b1;
                                if (r_cmd == CMD_PUSH_REAR) begin
                                    ctl.asel = ASEL_REAR_FREE;
                                    ctl.upd  = UPD_PUSH_REAR;
                                end else begin
                                    ctl.asel = ASEL_FRONT_NEW;
                                    ctl.upd  = UPD_PUSH_FRONT;
                                end
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_POP_REAR, CMD_POP_FRONT: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                ctl.emit        = 1'b1;
                                ctl.emit_last   = 1'b1;
                                ctl.emit_status = ST_EMPTY;
                                n_state         = S_IDLE;
                            end
                        end else begin
                            // read the slot and retire it in the same cycle
                            ctl.ram_rd = 1'b1;
                            if (r_cmd == CMD_POP_REAR) begin
                                ctl.asel = ASEL_REAR_LAST;
                                ctl.upd  = UPD_POP_REAR;
                            end else begin
                                ctl.asel = ASEL_HEAD;
                                ctl.upd  = UPD_POP_FRONT;
                            end
                            n_state = S_POP_WAIT;
                        end
                    end
                    CMD_DUMP: begin
                        if (i_stat.empty) begin
                            if (i_stat.out_free) begin
                                ctl.emit        = 1'b1;
                                ctl.emit_last   = 1'b1;
                                ctl.emit_status = ST_EMPTY;
                                n_state         = S_IDLE;
                            end
                        end else begin
                            ctl.dump_clr = 1'b1;
                            n_state      = S_DUMP_RD;
                        end
                    end
                    default: n_state = S_IDLE;   // unknown command: no result
                endcase
            end
            S_POP_WAIT: begin
                if (i_stat.out_free) begin
                    ctl.emit        = 1'b1;
                    ctl.emit_ram    = 1'b1;
                    ctl.emit_last   = 1'b1;
                    ctl.emit_status = ST_OK;
                    n_state         = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                ctl.ram_rd = 1'b1;
                ctl.asel   = ASEL_DUMP;
                n_state    = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_stat.out_free) begin
                    ctl.emit        = 1'b1;
                    ctl.emit_ram    = 1'b1;
                    ctl.emit_last   = i_stat.dump_last;
                    ctl.emit_status = ST_OK;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ctl.dump_inc = 1'b1;
                        n_state      = S_DUMP_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_ctl      = ctl;

endmodule

`default_nettype wire

>>> hw/rtl/bounded_deque_engine.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 32-bit words on a ring RAM.
// ----------------------------------------------------------------------------
// One command per input transfer: push rear, push front, pop rear, pop front
// or dump. Every push and pop gives one result; a dump gives one result per
// stored word, front to rear, with tlast on the rear word (one EMPTY result
// if nothing is stored). A push to a full queue gives FULL and changes
// nothing; unknown commands give no result. Commands are taken one at a time.
// A pop or dump that returns stored words is slower than a push, since each
// such word must pass through the ring RAM's registered read port, and a
// stalled output holds the running command. The next command is taken while
// the last result still sits in the output register. Stored words have no
// reset; there is no clearing pass after reset.
`default_nettype none

module bounded_deque_engine #(
    parameter int DEPTH = 16    // ring slots, 2 to 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value (signed)
    input  wire logic [7:0]  s_axis_tuser,   // [2:0] command, [7:3] zero
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] word (signed)
    output logic      [1:0]  m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast    // last result of the command
);

    import bde_pkg::*;

    t_ctl_cmd ctl;
    t_dp_stat stat;

    // sequencer: owns the handshake on the command side
    bde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_cmd      (s_axis_tuser[CMD_W-1:0]),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // ring store, pointers and the result register
    bde_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_value    (s_axis_tdata),
        .o_stat     (stat),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bde_checker.sv
// ----------------------------------------------------------------------------
// bde_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bde_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    import bde_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // EMPTY and FULL are single-result commands
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_FULL)
            |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("error status with data or without tlast");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_EMPTY
            || m_axis_tuser == ST_FULL))
        else $error("unknown status code");

    // a command is taken only once the previous one has issued its last result
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while another is running");

endmodule

bind bounded_deque_engine bde_checker u_bde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
